FILE: hdl/vv2d_pkg.sv
// ----------------------------------------------------------------------------
// vv2d_pkg: shared constants for the 2-D velocity Verlet core
// Fixed-point constants, register indexes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package vv2d_pkg;

  localparam int WORD_BITS_DEF    = 40;
  localparam int CORDIC_ITERS_DEF = 24;

  localparam int FIELD_BITS = 40;
  localparam int DT_BITS    = 24;
  localparam int LIMIT_BITS = 16;
  localparam int ACC_BITS   = 26;
  localparam int ANG_BITS   = 28;

  localparam logic [23:0] TIME_STEP_RST  = 24'd335544;
  localparam logic [15:0] STEP_LIMIT_RST = 16'd5000;

  localparam logic [26:0] TWO_PI_Q  = 27'd105414357;
  localparam logic [26:0] PI_Q      = 27'd52707179;
  localparam logic [26:0] HALF_PI_Q = 27'd26353589;
  localparam logic [27:0] CORDIC_GAIN = 28'd10188014;

  // floor(2^51 / TWO_PI_Q), i.e. 2^27/2pi: quotient estimate for one 24-bit reduction digit
  localparam logic [24:0] TWO_PI_RECIP = 25'((64'd1 << 51) / 64'(TWO_PI_Q));

  typedef enum logic {
    CFG_TIME_STEP  = 1'b0,
    CFG_STEP_LIMIT = 1'b1
  } cfg_index_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } opcode_t;

  function automatic logic [24:0] atan_q(input logic [4:0] i);
    logic [24:0] r;
    unique case (i)
      5'd0:  r = 25'd13176795;
      5'd1:  r = 25'd7778716;
      5'd2:  r = 25'd4110060;
      5'd3:  r = 25'd2086331;
      5'd4:  r = 25'd1047214;
      5'd5:  r = 25'd524117;
      5'd6:  r = 25'd262123;
      5'd7:  r = 25'd131069;
      5'd8:  r = 25'd65536;
      5'd9:  r = 25'd32768;
      5'd10: r = 25'd16384;
      5'd11: r = 25'd8192;
      5'd12: r = 25'd4096;
      5'd13: r = 25'd2048;
      5'd14: r = 25'd1024;
      5'd15: r = 25'd512;
      5'd16: r = 25'd256;
      5'd17: r = 25'd128;
      5'd18: r = 25'd64;
      5'd19: r = 25'd32;
      5'd20: r = 25'd16;
      5'd21: r = 25'd8;
      5'd22: r = 25'd4;
      5'd23: r = 25'd2;
      5'd24: r = 25'd1;
      default: r = 25'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/velocity_verlet_2d_trig_field_core.sv
// ----------------------------------------------------------------------------
// velocity_verlet_2d_trig_field_core
// Velocity Verlet integrator for a unit mass in the field (cos x, sin y).
// ----------------------------------------------------------------------------
// One request at a time. A step on a finished run goes straight to the
// result. The run time of a load or a step is set by the CORDIC (one
// rotation a cycle) and the 2*pi angle reduction (for each of the
// ceil(WORD_BITS/24) 24-bit digits of the position: a reciprocal multiply,
// a multiply back and a subtract with correction), both run once per axis,
// plus a shared 28x26 multiplier used for the products. The result sits in
// an output register and may wait there while the next request is taken;
// that request's completion then holds until the waiting result is accepted.
module velocity_verlet_2d_trig_field_core #(
  parameter int WORD_BITS    = vv2d_pkg::WORD_BITS_DEF,
  parameter int CORDIC_ITERS = vv2d_pkg::CORDIC_ITERS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // init_pos_x, init_pos_y, init_vel_x, init_vel_y
  input  logic [159:0] s_axis_tdata,
  // opcode
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // step_index, pos_x, pos_y, vel_x, vel_y, finished, zero pad
  output logic [183:0] m_axis_tdata,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [23:0]  cfg_data
);

  localparam int W     = WORD_BITS;
  localparam int NC    = (W + 23) / 24;
  localparam int CH_W  = (NC > 1) ? $clog2(NC) : 1;
  localparam int ACC_W = NC * 24 + 25;
  localparam int SW    = ((W > 52) ? W : 52) + 1;
  localparam int IT_W  = $clog2(CORDIC_ITERS);

  localparam logic signed [SW-1:0] WMAX = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SW-1:0] WMIN = ~WMAX;
  localparam logic signed [SW-1:0] OMAX = {{(SW-39){1'b0}}, {39{1'b1}}};
  localparam logic signed [SW-1:0] OMIN = ~OMAX;

  localparam logic [28:0] R_TP1 = 29'(vv2d_pkg::TWO_PI_Q);
  localparam logic [28:0] R_TP2 = {1'b0, vv2d_pkg::TWO_PI_Q, 1'b0};

  typedef enum logic [4:0] {
    ST_IDLE, ST_DT2, ST_DT2_W, ST_VDT, ST_VDT_W, ST_ADT, ST_ADT_W,
    ST_TSTART, ST_RQ, ST_RP, ST_RW, ST_FOLD, ST_ROT, ST_TDONE, ST_VEL,
    ST_VEL_W, ST_FIN
  } state_t;

  state_t state;

  logic [23:0] time_step;
  logic [15:0] step_limit;

  logic signed [W-1:0] pos_x, pos_y, vel_x, vel_y;
  logic signed [25:0]  acc_x, acc_y, a0_x, a0_y;
  logic [15:0]         steps;
  logic [22:0]         hdt2;
  logic                axis, stepping;
  logic [CH_W-1:0]     chunk;
  logic signed [ACC_W-1:0] acc;
  logic signed [53:0]  p;
  logic [W-1:0]        u;
  logic [26:0]         rm;
  logic                neg_in, negf;
  logic signed [27:0]  cr, xs, ys;
  logic [IT_W-1:0]     it;

  logic [15:0]         o_idx;
  logic signed [39:0]  o_px, o_py, o_vx, o_vy;
  logic                o_fin, m_valid;

  function automatic logic signed [W-1:0] sat_w(input logic signed [SW-1:0] v);
    if (v > WMAX) return WMAX[W-1:0];
    else if (v < WMIN) return WMIN[W-1:0];
    else return v[W-1:0];
  endfunction

  function automatic logic signed [39:0] sat_o(input logic signed [W-1:0] v);
    logic signed [SW-1:0] e;
    e = SW'(v);
    if (e > OMAX) return OMAX[39:0];
    else if (e < OMIN) return OMIN[39:0];
    else return e[39:0];
  endfunction

  function automatic logic signed [25:0] sat_a(input logic signed [27:0] v);
    if (v > 28'sd33554431) return 26'sd33554431;
    else if (v < -28'sd33554432) return -26'sd33554432;
    else return v[25:0];
  endfunction

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      time_step  <= vv2d_pkg::TIME_STEP_RST;
      step_limit <= vv2d_pkg::STEP_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (vv2d_pkg::cfg_index_t'(cfg_index))
        vv2d_pkg::CFG_TIME_STEP:  time_step  <= cfg_data;
        vv2d_pkg::CFG_STEP_LIMIT: step_limit <= cfg_data[15:0];
      endcase
    end
  end

  logic signed [39:0] in_px, in_py, in_vx, in_vy;
  assign in_px = s_axis_tdata[39:0];
  assign in_py = s_axis_tdata[79:40];
  assign in_vx = s_axis_tdata[119:80];
  assign in_vy = s_axis_tdata[159:120];

  logic signed [W-1:0]    cur_pos, cur_vel;
  logic signed [25:0]     cur_a0, cur_acc;
  logic signed [NC*24-1:0] vext;
  logic [23:0]            cv;
  logic signed [27:0]     ma;
  logic signed [25:0]     mb;
  logic signed [W-1:0]    vdt;
  logic [NC*24-1:0]       uext;
  logic [23:0]            uc;
  logic [28:0]            rd;
  logic [26:0]            rd_fix;
  logic [26:0]            r0;
  logic signed [27:0]     r1, sx, sy, fx, fy;
  logic [24:0]            at;

  assign cur_pos = axis ? pos_y : pos_x;
  assign cur_vel = axis ? vel_y : vel_x;
  assign cur_a0  = axis ? a0_y : a0_x;
  assign cur_acc = axis ? acc_y : acc_x;
  assign vext    = (NC*24)'(cur_vel);
  assign cv      = vext[int'(chunk)*24 +: 24];
  assign vdt     = W'(acc >>> 24);
  assign uext    = (NC*24)'(u);
  assign uc      = uext[int'(chunk)*24 +: 24];
  assign rd      = {rm[4:0], uc} - p[28:0];
  assign rd_fix  = (rd >= R_TP2) ? 27'(rd - R_TP2) :
                   ((rd >= R_TP1) ? 27'(rd - R_TP1) : rd[26:0]);
  assign r0      = (neg_in && rm != 27'd0) ? vv2d_pkg::TWO_PI_Q - rm : rm;
  assign r1      = (r0 >= vv2d_pkg::PI_Q) ? 28'(r0) - 28'(vv2d_pkg::TWO_PI_Q) : 28'(r0);
  assign sx      = xs >>> it;
  assign sy      = ys >>> it;
  assign at      = vv2d_pkg::atan_q(5'(it));
  assign fx      = negf ? -xs : xs;
  assign fy      = negf ? -ys : ys;

  // shared multiplier operands
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state)
      ST_DT2: begin
        ma = 28'(time_step);
        mb = 26'(time_step);
      end
      ST_VDT: begin
        ma = (chunk == CH_W'(NC-1)) ? 28'(signed'(cv)) : 28'(cv);
        mb = 26'(time_step);
      end
      ST_ADT: begin
        ma = 28'(cur_a0);
        mb = 26'(hdt2);
      end
      ST_RQ: begin
        ma = 28'(rm);
        mb = 26'(vv2d_pkg::TWO_PI_RECIP);
      end
      ST_RP: begin
        ma = 28'(vv2d_pkg::TWO_PI_Q);
        mb = 26'(p[51:27]);
      end
      ST_VEL: begin
        ma = 28'(cur_a0) + 28'(cur_acc);
        mb = 26'(time_step);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign s_axis_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    p <= 54'(ma * mb);
    if (rst) begin
      state    <= ST_IDLE;
      m_valid  <= 1'b0;
      pos_x    <= '0;
      pos_y    <= '0;
      vel_x    <= '0;
      vel_y    <= '0;
      acc_x    <= 26'sd16777216;
      acc_y    <= '0;
      steps    <= '0;
      axis     <= 1'b0;
      stepping <= 1'b0;
    end else begin
      if (m_axis_tready) m_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            axis <= 1'b0;
            if (vv2d_pkg::opcode_t'(s_axis_tuser) == vv2d_pkg::OP_LOAD) begin
              pos_x    <= sat_w(SW'(in_px));
              pos_y    <= sat_w(SW'(in_py));
              vel_x    <= sat_w(SW'(in_vx));
              vel_y    <= sat_w(SW'(in_vy));
              steps    <= '0;
              stepping <= 1'b0;
              state    <= ST_TSTART;
            end else if (steps < step_limit) begin
              stepping <= 1'b1;
              a0_x     <= acc_x;
              a0_y     <= acc_y;
              state    <= ST_DT2;
            end else begin
              state <= ST_FIN;
            end
          end
        end
        ST_DT2: state <= ST_DT2_W;
        ST_DT2_W: begin
          hdt2  <= p[47:25];
          chunk <= CH_W'(NC-1);
          acc   <= '0;
          state <= ST_VDT;
        end
        ST_VDT: state <= ST_VDT_W;
        ST_VDT_W: begin
          acc <= (acc <<< 24) + ACC_W'(p);
          if (chunk == '0) state <= ST_ADT;
          else begin
            chunk <= chunk - 1'b1;
            state <= ST_VDT;
          end
        end
        ST_ADT: begin
          if (axis) pos_y <= sat_w(SW'(pos_y) + SW'(vdt));
          else pos_x <= sat_w(SW'(pos_x) + SW'(vdt));
          state <= ST_ADT_W;
        end
        ST_ADT_W: begin
          if (axis) pos_y <= sat_w(SW'(pos_y) + SW'(p >>> 24));
          else pos_x <= sat_w(SW'(pos_x) + SW'(p >>> 24));
          if (!axis) begin
            axis  <= 1'b1;
            chunk <= CH_W'(NC-1);
            acc   <= '0;
            state <= ST_VDT;
          end else begin
            axis  <= 1'b0;
            state <= ST_TSTART;
          end
        end
        ST_TSTART: begin
          neg_in <= cur_pos[W-1];
          u      <= cur_pos[W-1] ? W'(-cur_pos) : W'(cur_pos);
          rm     <= '0;
          chunk  <= CH_W'(NC-1);
          state  <= ST_RQ;
        end
        ST_RQ: state <= ST_RP;
        ST_RP: state <= ST_RW;
        ST_RW: begin
          rm <= rd_fix;
          if (chunk == '0) state <= ST_FOLD;
          else begin
            chunk <= chunk - 1'b1;
            state <= ST_RQ;
          end
        end
        ST_FOLD: begin
          priority if (r1 > $signed(28'(vv2d_pkg::HALF_PI_Q))) begin
            cr   <= r1 - $signed(28'(vv2d_pkg::PI_Q));
            negf <= 1'b1;
          end else if (r1 < -$signed(28'(vv2d_pkg::HALF_PI_Q))) begin
            cr   <= r1 + $signed(28'(vv2d_pkg::PI_Q));
            negf <= 1'b1;
          end else begin
            cr   <= r1;
            negf <= 1'b0;
          end
          xs    <= vv2d_pkg::CORDIC_GAIN;
          ys    <= '0;
          it    <= '0;
          state <= ST_ROT;
        end
        ST_ROT: begin
          if (!cr[27]) begin
            xs <= xs - sy;
            ys <= ys + sx;
            cr <= cr - 28'(at);
          end else begin
            xs <= xs + sy;
            ys <= ys - sx;
            cr <= cr + 28'(at);
          end
          if (it == IT_W'(CORDIC_ITERS-1)) state <= ST_TDONE;
          else it <= it + 1'b1;
        end
        ST_TDONE: begin
          if (!axis) begin
            acc_x <= sat_a(fx);
            axis  <= 1'b1;
            state <= ST_TSTART;
          end else begin
            acc_y <= sat_a(fy);
            axis  <= 1'b0;
            state <= stepping ? ST_VEL : ST_FIN;
          end
        end
        ST_VEL: state <= ST_VEL_W;
        ST_VEL_W: begin
          if (axis) vel_y <= sat_w(SW'(vel_y) + SW'(p >>> 25));
          else vel_x <= sat_w(SW'(vel_x) + SW'(p >>> 25));
          if (!axis) begin
            axis  <= 1'b1;
            state <= ST_VEL;
          end else begin
            axis  <= 1'b0;
            steps <= steps + 1'b1;
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!m_valid || m_axis_tready) begin
            o_idx   <= steps;
            o_px    <= sat_o(pos_x);
            o_py    <= sat_o(pos_y);
            o_vx    <= sat_o(vel_x);
            o_vy    <= sat_o(vel_y);
            o_fin   <= (steps >= step_limit);
            m_valid <= 1'b1;
            state   <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = {7'd0, o_fin, o_vy, o_vx, o_py, o_px, o_idx};

  a_req_blocks: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request taken while busy");

  a_fin_flag: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[176] == (m_axis_tdata[15:0] >= step_limit)))
    else $error("finished flag disagrees with step count");

  a_res_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> ($past(state) == ST_FIN))
    else $error("result raised outside completion");

endmodule

FILE: tb/velocity_verlet_2d_trig_field_checker.sv
// ----------------------------------------------------------------------------
// velocity_verlet_2d_trig_field_checker
// Watches the request, result and register-write channels of the core.
// Keeps its own copy of the integrator state, works out the result of every
// accepted request and compares each accepted result field by field.
// ----------------------------------------------------------------------------
module velocity_verlet_2d_trig_field_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [159:0] s_axis_tdata,
  input  logic [0:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [183:0] m_axis_tdata,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [23:0]  cfg_data,
  output int           failures,
  output int           pending
);

  localparam longint WMAX = (64'sd1 <<< 39) - 1;
  localparam longint WMIN = -WMAX - 1;
  localparam longint AMAX = 33554431;
  localparam longint AMIN = -AMAX - 1;

  typedef struct {
    logic [15:0] step_index;
    logic [39:0] pos_x;
    logic [39:0] pos_y;
    logic [39:0] vel_x;
    logic [39:0] vel_y;
    logic        finished;
  } state_report_t;

  state_report_t reports_due[$];

  longint dt_q, limit_q;
  longint px, py, vx, vy, ax, ay;
  int     steps;

  function automatic longint atan_step(input int i);
    longint t [25] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123,
                       131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
                       256, 128, 64, 32, 16, 8, 4, 2, 1};
    return (i < 25) ? t[i] : 0;
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint sat_sum(input longint a, input longint b);
    if (b > 0 && a > WMAX - b) return WMAX;
    if (b < 0 && a < WMIN - b) return WMIN;
    return a + b;
  endfunction

  function automatic longint scale_dt(input longint a, input longint b);
    longint hi, lo;
    hi = a >>> 24;
    lo = a & 64'hFF_FFFF;
    return hi * b + ((lo * b) >>> 24);
  endfunction

  task automatic cordic_trig(input longint ang, output longint c, output longint s);
    longint r, xs, ys, t;
    bit     flip;
    r = ang % 64'sd105414357;
    xs = 10188014;
    ys = 0;
    flip = 0;
    if (r < 0) r += 105414357;
    if (r >= 52707179) r -= 105414357;
    if (r > 26353589) begin
      r -= 52707179;
      flip = 1;
    end else if (r < -26353589) begin
      r += 52707179;
      flip = 1;
    end
    for (int i = 0; i < 24; i++) begin
      if (r >= 0) begin
        t = xs - (ys >>> i); ys = ys + (xs >>> i); r -= atan_step(i);
      end else begin
        t = xs + (ys >>> i); ys = ys - (xs >>> i); r += atan_step(i);
      end
      xs = t;
    end
    if (flip) begin
      xs = -xs;
      ys = -ys;
    end
    c = clip(xs, AMIN, AMAX);
    s = clip(ys, AMIN, AMAX);
  endtask

  task automatic refresh_field();
    longint c, s;
    cordic_trig(px, c, s);
    ax = c;
    cordic_trig(py, c, s);
    ay = s;
  endtask

  task automatic advance(input logic op, input logic [159:0] d);
    longint hdt2, ax0, ay0;
    state_report_t rep;
    if (op == vv2d_pkg::OP_LOAD) begin
      px = longint'($signed(d[39:0]));
      py = longint'($signed(d[79:40]));
      vx = longint'($signed(d[119:80]));
      vy = longint'($signed(d[159:120]));
      steps = 0;
      refresh_field();
    end else if (steps < limit_q) begin
      hdt2 = (dt_q * dt_q) >>> 25;
      ax0 = ax;
      ay0 = ay;
      px = sat_sum(sat_sum(px, scale_dt(vx, dt_q)), (ax0 * hdt2) >>> 24);
      py = sat_sum(sat_sum(py, scale_dt(vy, dt_q)), (ay0 * hdt2) >>> 24);
      refresh_field();
      vx = sat_sum(vx, ((ax0 + ax) * dt_q) >>> 25);
      vy = sat_sum(vy, ((ay0 + ay) * dt_q) >>> 25);
      steps = (steps + 1) & 16'hFFFF;
    end
    rep.step_index = steps[15:0];
    rep.pos_x = px[39:0];
    rep.pos_y = py[39:0];
    rep.vel_x = vx[39:0];
    rep.vel_y = vy[39:0];
    rep.finished = (steps >= limit_q);
    reports_due.push_back(rep);
  endtask

  task automatic compare_field(input string name, input logic [39:0] exp_v,
                               input logic [39:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    state_report_t rep;
    if (rst) begin
      dt_q = longint'(vv2d_pkg::TIME_STEP_RST);
      limit_q = longint'(vv2d_pkg::STEP_LIMIT_RST);
      px = 0; py = 0; vx = 0; vy = 0;
      ax = 64'sd1 <<< 24;
      ay = 0;
      steps = 0;
      reports_due.delete();
      failures = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (reports_due.size() == 0) begin
          $error("result with no request outstanding: %h", m_axis_tdata);
          failures++;
        end else begin
          rep = reports_due.pop_front();
          compare_field("step_index", 40'(rep.step_index), 40'(m_axis_tdata[15:0]));
          compare_field("pos_x", rep.pos_x, m_axis_tdata[55:16]);
          compare_field("pos_y", rep.pos_y, m_axis_tdata[95:56]);
          compare_field("vel_x", rep.vel_x, m_axis_tdata[135:96]);
          compare_field("vel_y", rep.vel_y, m_axis_tdata[175:136]);
          compare_field("finished", 40'(rep.finished), 40'(m_axis_tdata[176]));
        end
      end
      if (s_axis_tvalid && s_axis_tready) advance(s_axis_tuser[0], s_axis_tdata);
      if (cfg_we) begin
        if (cfg_index == vv2d_pkg::CFG_TIME_STEP) dt_q = longint'(cfg_data);
        else limit_q = longint'(cfg_data[15:0]);
      end
    end
    pending = reports_due.size();
  end

endmodule

FILE: tb/tb_velocity_verlet_2d_trig_field_core.sv
// ----------------------------------------------------------------------------
// tb_velocity_verlet_2d_trig_field_core
// Drives load and step requests into the Verlet core under several register
// settings and idling patterns; the checker beside the core judges results.
// ----------------------------------------------------------------------------
module tb_velocity_verlet_2d_trig_field_core;

  localparam int WATCHDOG_LIMIT = 20000;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [159:0] s_axis_tdata = '0;
  logic [0:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [183:0] m_axis_tdata;
  logic         cfg_we = 0;
  logic [0:0]   cfg_index = '0;
  logic [23:0]  cfg_data = '0;
  int           failures, pending;
  int           idle_pct = 0, stall_pct = 0, quiet_cycles = 0;

  always #10 clk = ~clk;

  velocity_verlet_2d_trig_field_core dut (.*);

  velocity_verlet_2d_trig_field_checker checker_i (.*);

  always @(posedge clk) begin
    if (rst) m_axis_tready <= 0;
    else m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [39:0] pick_word();
    case ($urandom_range(5))
      0: return 40'({$urandom, $urandom});
      1: return 40'h7F_FFFF_FFFF;
      2: return 40'h80_0000_0000;
      default: return 40'($signed($urandom_range(32'h3FFF_FFFF)) - 32'sh2000_0000);
    endcase
  endfunction

  task automatic send(input vv2d_pkg::opcode_t op, input logic [159:0] d);
    if ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= op;
    s_axis_tdata <= d;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic load_state();
    send(vv2d_pkg::OP_LOAD, {pick_word(), pick_word(), pick_word(), pick_word()});
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input vv2d_pkg::cfg_index_t idx, input logic [23:0] val);
    drain();
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // defaults
    send(vv2d_pkg::OP_STEP, '0);
    send(vv2d_pkg::OP_LOAD, '0);
    send(vv2d_pkg::OP_STEP, '0);
    send(vv2d_pkg::OP_LOAD, {4{40'h7F_FFFF_FFFF}});
    send(vv2d_pkg::OP_STEP, '0);
    send(vv2d_pkg::OP_STEP, '0);
    send(vv2d_pkg::OP_LOAD, {4{40'h80_0000_0000}});
    send(vv2d_pkg::OP_STEP, '0);
    drain();
    send(vv2d_pkg::OP_LOAD,
         {40'h00_0300_0000, 40'hFF_FD00_0000, 40'h00_0100_0000, 40'hFF_0000_0000});
    send(vv2d_pkg::OP_STEP, '0);
    // zero time step
    write_reg(vv2d_pkg::CFG_TIME_STEP, 24'd0);
    send(vv2d_pkg::OP_STEP, '0);
    send(vv2d_pkg::OP_STEP, '0);
    // largest time step, short run then frozen
    write_reg(vv2d_pkg::CFG_TIME_STEP, 24'hFF_FFFF);
    write_reg(vv2d_pkg::CFG_STEP_LIMIT, 24'd3);
    load_state();
    repeat (5) send(vv2d_pkg::OP_STEP, '0);
    // zero limit: load already finished
    write_reg(vv2d_pkg::CFG_STEP_LIMIT, 24'd0);
    load_state();
    send(vv2d_pkg::OP_STEP, '0);
    write_reg(vv2d_pkg::CFG_STEP_LIMIT, 24'hFFFF);
    write_reg(vv2d_pkg::CFG_TIME_STEP, 24'd1);
    load_state();
    send(vv2d_pkg::OP_STEP, '0);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 67; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 67; end
        default: begin idle_pct = 38; stall_pct = 38; end
      endcase
      write_reg(vv2d_pkg::CFG_TIME_STEP, (ph == 3) ? 24'hFF_FFFF : (ph == 6) ? 24'd1 :
                24'($urandom_range(24'hFF_FFFF, 1)));
      write_reg(vv2d_pkg::CFG_STEP_LIMIT, (ph == 5) ? 24'hFFFF : (ph == 7) ? 24'd0 :
                24'($urandom_range(30)));
      for (int n = 0; n < 50; ) begin
        if ($urandom_range(9) == 0) begin
          send(vv2d_pkg::OP_STEP, {$urandom, $urandom, $urandom, $urandom, $urandom});
          n++;
        end else begin
          load_state();
          n++;
          repeat ($urandom_range(12, 1)) begin
            send(vv2d_pkg::OP_STEP, {$urandom, $urandom, $urandom, $urandom, $urandom});
            n++;
          end
        end
      end
    end

    s_axis_tvalid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (failures == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
